// ----- design/kpwdg_pkg.sv -----
// Package for the key protected watchdog: request and response word types,
// bus mode codes, key values and the prescaler period function.
// Depends on nothing; used by kpwdg_core and key_protected_watchdog.
package kpwdg_pkg;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] write_data;
  } kpwdg_req_t;

  typedef struct packed {
    logic [1:0]  status_bits;
    logic [11:0] count_value;
    logic        is_running;
    logic        watchdog_reset;
  } kpwdg_rsp_t;

  localparam logic [2:0] MODE_KEY      = 3'd0;
  localparam logic [2:0] MODE_PRESCALE = 3'd1;
  localparam logic [2:0] MODE_RELOAD   = 3'd2;
  localparam logic [2:0] MODE_STATUS   = 3'd3;
  localparam logic [2:0] MODE_TICK     = 3'd4;

  localparam logic [15:0] KEY_UNLOCK = 16'h5555;
  localparam logic [15:0] KEY_RELOAD = 16'hAAAA;
  localparam logic [15:0] KEY_START  = 16'hCCCC;

  localparam logic [2:0] PRESCALE_TOP_CODE = 3'd6;

  localparam int ST_PVU = 0;
  localparam int ST_RVU = 1;

  // Divider period is 4 << code; the two top codes share the longest period.
  function automatic logic [8:0] divider_period(input logic [2:0] code);
    logic [2:0] c;
    c = (code > PRESCALE_TOP_CODE) ? PRESCALE_TOP_CODE : code;
    return 9'(9'd4 << c);
  endfunction

endpackage

// ----- design/kpwdg_core.sv -----
// Watchdog state and the combinational step logic for one bus access or tick.
// Depends on kpwdg_pkg.
module kpwdg_core #(
  parameter int SYNC_TICKS  = 3,
  parameter int RELOAD_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  kpwdg_pkg::kpwdg_req_t req,
  output kpwdg_pkg::kpwdg_rsp_t rsp
);
  import kpwdg_pkg::*;

  localparam logic [3:0]             SyncLoad    = 4'(SYNC_TICKS);
  localparam logic [RELOAD_BITS-1:0] ResetReload = RELOAD_BITS'(32'h0FFF);

  logic                   running,         running_next;
  logic                   write_unlocked,  write_unlocked_next;
  logic [2:0]             prescale_active, prescale_active_next;
  logic [2:0]             prescale_pending, prescale_pending_next;
  logic [RELOAD_BITS-1:0] reload_active,   reload_active_next;
  logic [RELOAD_BITS-1:0] reload_pending,  reload_pending_next;
  logic [RELOAD_BITS-1:0] down_counter,    down_counter_next;
  logic [7:0]             divider_count,   divider_count_next;
  logic [3:0]             prescale_sync_left, prescale_sync_left_next;
  logic [3:0]             reload_sync_left,   reload_sync_left_next;
  logic                   expired;

  always_comb begin
    running_next            = running;
    write_unlocked_next     = write_unlocked;
    prescale_active_next    = prescale_active;
    prescale_pending_next   = prescale_pending;
    reload_active_next      = reload_active;
    reload_pending_next     = reload_pending;
    down_counter_next       = down_counter;
    divider_count_next      = divider_count;
    prescale_sync_left_next = prescale_sync_left;
    reload_sync_left_next   = reload_sync_left;
    expired                 = 1'b0;

    unique case (req.mode)
      MODE_KEY: begin
        if (req.write_data == KEY_UNLOCK) begin
          write_unlocked_next = 1'b1;
        end else begin
          write_unlocked_next = 1'b0;
          if (req.write_data == KEY_RELOAD) begin
            down_counter_next = reload_active;
          end else if (req.write_data == KEY_START) begin
            running_next = 1'b1;
          end
        end
      end
      MODE_PRESCALE: begin
        if (write_unlocked) begin
          prescale_pending_next   = req.write_data[2:0];
          prescale_sync_left_next = SyncLoad;
        end
      end
      MODE_RELOAD: begin
        if (write_unlocked) begin
          reload_pending_next   = req.write_data[RELOAD_BITS-1:0];
          reload_sync_left_next = SyncLoad;
        end
      end
      MODE_TICK: begin
        // Pending values land first, so this tick already uses them.
        if (prescale_sync_left != 4'd0) begin
          prescale_sync_left_next = prescale_sync_left - 4'd1;
          if (prescale_sync_left == 4'd1) begin
            prescale_active_next = prescale_pending;
          end
        end
        if (reload_sync_left != 4'd0) begin
          reload_sync_left_next = reload_sync_left - 4'd1;
          if (reload_sync_left == 4'd1) begin
            reload_active_next = reload_pending;
          end
        end
        if (running) begin
          if ({1'b0, divider_count} + 9'd1 >= divider_period(prescale_active_next)) begin
            divider_count_next = 8'd0;
            if (down_counter <= RELOAD_BITS'(1)) begin
              expired           = 1'b1;
              down_counter_next = reload_active_next;
            end else begin
              down_counter_next = down_counter - RELOAD_BITS'(1);
            end
          end else begin
            divider_count_next = divider_count + 8'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rsp.status_bits[ST_PVU] = (prescale_sync_left_next != 4'd0);
    rsp.status_bits[ST_RVU] = (reload_sync_left_next != 4'd0);
    rsp.count_value         = 12'(down_counter_next);
    rsp.is_running          = running_next;
    rsp.watchdog_reset      = expired;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running            <= 1'b0;
      write_unlocked     <= 1'b0;
      prescale_active    <= 3'd0;
      prescale_pending   <= 3'd0;
      reload_active      <= ResetReload;
      reload_pending     <= ResetReload;
      down_counter       <= ResetReload;
      divider_count      <= 8'd0;
      prescale_sync_left <= 4'd0;
      reload_sync_left   <= 4'd0;
    end else if (step) begin
      running            <= running_next;
      write_unlocked     <= write_unlocked_next;
      prescale_active    <= prescale_active_next;
      prescale_pending   <= prescale_pending_next;
      reload_active      <= reload_active_next;
      reload_pending     <= reload_pending_next;
      down_counter       <= down_counter_next;
      divider_count      <= divider_count_next;
      prescale_sync_left <= prescale_sync_left_next;
      reload_sync_left   <= reload_sync_left_next;
    end
  end

`ifndef ASSERT_OFF
  a_expire_on_tick: assert property (@(posedge clk) disable iff (rst)
    step && expired |-> req.mode == MODE_TICK)
    else $error("watchdog reset flagged on a step that is not a tick");

  a_expire_reloads: assert property (@(posedge clk) disable iff (rst)
    step && expired |=> down_counter == reload_active)
    else $error("counter did not reload from the active value on expiry");

  a_running_sticks: assert property (@(posedge clk) disable iff (rst)
    running |=> running)
    else $error("running cleared without reset");

  a_sync_bound: assert property (@(posedge clk) disable iff (rst)
    prescale_sync_left <= SyncLoad && reload_sync_left <= SyncLoad)
    else $error("sync count above its load value");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(down_counter) && $stable(divider_count))
    else $error("counter state changed without an accepted word");
`endif

endmodule

// ----- design/key_protected_watchdog.sv -----
// Top level of the key protected watchdog: request/response handshake and
// the response register. Depends on kpwdg_pkg and kpwdg_core.
//
// Every request word (key, prescaler or reload write, status read, or one
// slow-clock tick) is processed in the cycle it is accepted and yields one
// response word in the next cycle from the response register. The block takes
// one word per cycle; it stalls requests only while a held response is itself
// stalled, since the single response register is the only buffer.
module key_protected_watchdog #(
  parameter int SYNC_TICKS  = 3,
  parameter int RELOAD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  kpwdg_pkg::kpwdg_req_t req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output kpwdg_pkg::kpwdg_rsp_t rsp
);
  import kpwdg_pkg::*;

  logic       accept;
  kpwdg_rsp_t step_rsp;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  kpwdg_core #(
    .SYNC_TICKS  (SYNC_TICKS),
    .RELOAD_BITS (RELOAD_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (accept),
    .req  (req),
    .rsp  (step_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= step_rsp;
    end
  end

endmodule
